[sv/b58enc_pkg.sv]
// Shared types, constants and the alphabet lookup of the base-58 encoder.
package b58enc_pkg;

  localparam int RADIX        = 58;
  localparam int RESULT_LIMIT = 44;
  localparam int DIGIT_W      = 6;
  localparam int BYTE_W       = 8;
  localparam int CHAR_W       = 7;
  localparam int X_W          = DIGIT_W + BYTE_W;

  // floor(x / 58) == (x * RECIP) >> RECIP_SHIFT for every x below 58 * 256.
  localparam int             RECIP_SHIFT = 20;
  localparam int             RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP   = 15'd18079;

  localparam logic [CHAR_W-1:0] ZERO_CHAR = 7'd49;

  localparam logic [RADIX*8-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WR,
    S_EPREP,
    S_EMIT
  } seq_state_e;

  // The first character of the string literal sits in the top byte.
  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] idx;
    idx = (d >= DIGIT_W'(RADIX)) ? d - DIGIT_W'(RADIX) : d;
    return ALPHABET[(RADIX - 1 - int'(idx)) * 8 +: CHAR_W];
  endfunction

endpackage

[sv/b58enc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module b58enc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/b58enc_div58.sv]
// Shared divide-by-58 unit: reciprocal multiply, registered, then remainder with correction.
module b58enc_div58 import b58enc_pkg::*; (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [X_W-1:0]     x_i,
  output logic [BYTE_W-1:0]  quot_o,
  output logic [DIGIT_W-1:0] rem_o
);

  localparam int PROD_W = X_W + RECIP_W;
  localparam int QE_W   = PROD_W - RECIP_SHIFT;

  logic [X_W-1:0]    x_q;
  logic [PROD_W-1:0] prod_q;
  logic [QE_W-1:0]   q_est;
  logic [QE_W-1:0]   q_fix;
  logic [X_W-1:0]    r_full;
  logic [X_W-1:0]    r_fix;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q    <= x_i;
      prod_q <= PROD_W'(x_i) * PROD_W'(RECIP);
    end
  end

  always_comb begin
    q_est  = prod_q[RECIP_SHIFT +: QE_W];
    r_full = x_q - X_W'(q_est) * X_W'(RADIX);
    if (r_full >= X_W'(RADIX)) begin
      q_fix = q_est + 1'b1;
      r_fix = r_full - X_W'(RADIX);
    end else begin
      q_fix = q_est;
      r_fix = r_full;
    end
  end

  assign quot_o = q_fix[BYTE_W-1:0];
  assign rem_o  = r_fix[DIGIT_W-1:0];

endmodule

[sv/base58_encoder_top.sv]
// Top level of the base-58 encoder: sequencer, digit memory and shared divider.
//
// The block takes a message one byte a beat (start high while busy is low) and, after the
// beat that carries last_byte, returns its base-58 text in the Bitcoin alphabet, one
// character a beat on result_o marked by result_valid_o. A beat that is not final walks
// the stored digits one by one: the digits are kept in a single-port-read memory and
// every digit passes through the one divide-by-58 unit (a reciprocal multiply that is
// registered before the remainder is formed). A leading zero byte, or a byte dropped
// beyond MAX_BYTES, is taken without a fold. The final beat is followed by a set-up state
// and then the characters, back to back with no gaps. The receiver cannot hold results
// off: each character is present for exactly one cycle and must be taken then. busy is
// low between the bytes of a message once each fold is done; after the final beat it
// stays high until the last character of the message has gone. overflow is raised only
// on the last character, when bytes beyond MAX_BYTES were dropped or the text did not
// fit. The digit memory is not cleared after reset, since a digit is only ever read after
// it has been written.
module base58_encoder_top import b58enc_pkg::*; #(
  parameter int MAX_BYTES  = 32,
  parameter int MAX_DIGITS = 44
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  in_item_t  data_i,
  output logic      busy,
  output logic      result_valid_o,
  output out_item_t result_o
);

  localparam int KW  = $clog2(MAX_DIGITS + 1);
  localparam int AW  = $clog2(MAX_DIGITS);
  localparam int ZW  = $clog2(MAX_BYTES + 1);
  localparam int CAP = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
  localparam int RW  = $clog2(CAP + 1);
  localparam int SW  = ((ZW > KW) ? ZW : KW) + 1;

  seq_state_e        state_q, state_d;
  logic [KW-1:0]     k_q, k_d;
  logic [KW-1:0]     dcount_q, dcount_d;
  logic [BYTE_W-1:0] carry_q, carry_d;
  logic [ZW-1:0]     zpc_q, zpc_d;
  logic [ZW-1:0]     bcount_q, bcount_d;
  logic              seen_q, seen_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [ZW-1:0]     zleft_q, zleft_d;
  logic [KW-1:0]     didx_q, didx_d;

  // Memory and divider hook-up.
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;
  logic               div_load;
  logic [X_W-1:0]     div_x;
  logic [BYTE_W-1:0]  div_quot;
  logic [DIGIT_W-1:0] div_rem;

  logic [KW-1:0] nk;
  logic [KW-1:0] dcount_m1;
  logic [KW-1:0] didx_m2;
  logic [SW-1:0] total_sum;

  assign nk        = k_q + 1'b1;
  assign dcount_m1 = dcount_q - 1'b1;
  assign didx_m2   = didx_q - KW'(2);
  assign total_sum = SW'(zpc_q) + SW'(dcount_q);
  assign busy      = (state_q != S_IDLE);

  b58enc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (k_q[AW-1:0]),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  b58enc_div58 u_div (
    .clk_i  (clk_i),
    .load_i (div_load),
    .x_i    (div_x),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      dcount_q <= '0;
      zpc_q    <= '0;
      bcount_q <= '0;
      seen_q   <= 1'b0;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
      rem_q    <= '0;
      zleft_q  <= '0;
      didx_q   <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      dcount_q <= dcount_d;
      zpc_q    <= zpc_d;
      bcount_q <= bcount_d;
      seen_q   <= seen_d;
      ovf_q    <= ovf_d;
      last_q   <= last_d;
      rem_q    <= rem_d;
      zleft_q  <= zleft_d;
      didx_q   <= didx_d;
    end
  end

  // The running carry is payload: it is always loaded before it is used.
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  // Next state and outputs.
  always_comb begin
    logic fold_go;
    logic more_digits;
    logic keep_going;
    logic last_beat;

    fold_go     = 1'b0;
    more_digits = 1'b0;
    keep_going  = 1'b0;
    last_beat   = 1'b0;

    state_d  = state_q;
    k_d      = k_q;
    dcount_d = dcount_q;
    carry_d  = carry_q;
    zpc_d    = zpc_q;
    bcount_d = bcount_q;
    seen_d   = seen_q;
    ovf_d    = ovf_q;
    last_d   = last_q;
    rem_d    = rem_q;
    zleft_d  = zleft_q;
    didx_d   = didx_q;

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    div_load  = 1'b0;
    div_x     = {((k_q < dcount_q) ? ram_rdata : DIGIT_W'(0)), carry_q};

    result_valid_o = 1'b0;
    result_o       = '0;

    case (state_q)
      S_IDLE: begin
        // Keep the lowest digit fetched so that a fold can start at once.
        ram_re    = 1'b1;
        ram_raddr = '0;
        if (start) begin
          last_d  = data_i.last_byte;
          carry_d = data_i.data_byte;
          k_d     = '0;
          if (bcount_q < ZW'(MAX_BYTES)) begin
            bcount_d = bcount_q + 1'b1;
            if (data_i.data_byte == '0 && !seen_q) begin
              zpc_d = zpc_q + 1'b1;
            end else begin
              seen_d  = 1'b1;
              fold_go = (dcount_q != '0) || (data_i.data_byte != '0);
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (fold_go) begin
            state_d = S_MUL;
          end else if (data_i.last_byte) begin
            state_d = S_EPREP;
          end
        end
      end

      S_MUL: begin
        div_load = 1'b1;
        state_d  = S_WR;
      end

      S_WR: begin
        ram_we  = 1'b1;
        carry_d = div_quot;
        if (k_q >= dcount_q) begin
          dcount_d = nk;
        end
        more_digits = (nk < dcount_q);
        ram_re      = more_digits;
        ram_raddr   = nk[AW-1:0];
        keep_going  = more_digits || ((div_quot != '0) && (nk < KW'(MAX_DIGITS)));
        if (keep_going) begin
          k_d     = nk;
          state_d = S_MUL;
        end else begin
          if (div_quot != '0) begin
            ovf_d = 1'b1;
          end
          state_d = last_q ? S_EPREP : S_IDLE;
        end
      end

      S_EPREP: begin
        if (total_sum > SW'(CAP)) begin
          rem_d = RW'(CAP);
          ovf_d = 1'b1;
        end else begin
          rem_d = total_sum[RW-1:0];
        end
        zleft_d   = zpc_q;
        didx_d    = dcount_q;
        ram_re    = (dcount_q != '0);
        ram_raddr = dcount_m1[AW-1:0];
        state_d   = S_EMIT;
      end

      S_EMIT: begin
        result_valid_o = 1'b1;
        last_beat      = (rem_q == RW'(1));
        if (zleft_q != '0) begin
          result_o.char_code = ZERO_CHAR;
          zleft_d            = zleft_q - 1'b1;
        end else begin
          result_o.char_code = b58_char(ram_rdata);
          didx_d             = didx_q - 1'b1;
          ram_re             = (didx_q > KW'(1));
          ram_raddr          = didx_m2[AW-1:0];
        end
        result_o.last_char = last_beat;
        result_o.overflow  = last_beat && ovf_q;
        rem_d              = rem_q - 1'b1;
        if (last_beat) begin
          dcount_d = '0;
          zpc_d    = '0;
          bcount_d = '0;
          seen_d   = 1'b0;
          ovf_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // Characters are only produced while the block reports itself busy.
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result beat outside a busy period");

  // The digit count never runs past the memory depth.
  a_dcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcount_q <= KW'(MAX_DIGITS))
    else $error("digit count exceeds the digit memory");

  // The overflow flag only ever rides on the final character.
  a_ovf_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.overflow) |-> result_o.last_char)
    else $error("overflow raised on a character that is not the last");

  // After the final character the block is ready for a new message.
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_char) |=> !busy)
    else $error("block still busy after the final character");

  // A digit write always follows a divider load in the cycle before.
  a_write_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> $past(div_load))
    else $error("digit written without a fresh quotient");
`endif

endmodule

[tb/tb_base58_encoder_top.sv]
// Self-checking testbench of the base-58 encoder: byte messages in, predicted text checked.
`timescale 1ns / 1ps

module tb_base58_encoder_top;
  import b58enc_pkg::*;

  // Sizes of the instance under test; the prediction below follows the same values.
  localparam int MAX_BYTES  = 32;
  localparam int MAX_DIGITS = 44;

  // No encoding is ever longer than the smaller of the digit store and the result limit.
  localparam int CHAR_CAP = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;

  // The slowest beat walks every stored digit while no beat is taken and no character
  // returns. The limit leaves ample room for that and for the sender's idle gaps.
  localparam int STALL_LIMIT = 2000;

  // Settling time after the last character: one full-length byte walk and a little more.
  localparam int DRAIN_CYCLES = 2 * MAX_DIGITS + 8;

  localparam int MAX_REPORTS  = 10;
  localparam int TARGET_BEATS = 230;

  // The scoreboard keeps its own copy of the digit array and message counters, works out
  // the characters that each accepted beat causes and queues them, then compares every
  // character that the block returns with the oldest one still waiting.
  class encoding_board;
    bit [DIGIT_W-1:0] digits [MAX_DIGITS];
    int unsigned      n_digits;
    int unsigned      n_zeros;
    int unsigned      n_bytes;
    bit               nonzero_seen;
    bit               dropped;
    out_item_t        chars_due [$];
    int unsigned      failures;
    string            alphabet;

    function new();
      alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
      failures = 0;
      clear();
    endfunction

    // The message counters and flags return to their reset values; the stale digits stay.
    function void clear();
      n_digits     = 0;
      n_zeros      = 0;
      n_bytes      = 0;
      nonzero_seen = 1'b0;
      dropped      = 1'b0;
    endfunction

    // Multiply the little-endian digit array by 256 and add the byte.
    function void fold(int unsigned b);
      int unsigned carry;
      carry = b;
      for (int k = 0; k < n_digits; k++) begin
        carry     = carry + (int'(digits[k]) << BYTE_W);
        digits[k] = DIGIT_W'(carry % RADIX);
        carry     = carry / RADIX;
      end
      while (carry != 0 && n_digits < MAX_DIGITS) begin
        digits[n_digits] = DIGIT_W'(carry % RADIX);
        carry            = carry / RADIX;
        n_digits++;
      end
      if (carry != 0) begin
        dropped = 1'b1;
      end
    endfunction

    function out_item_t char_of(int unsigned idx);
      out_item_t c;
      byte       ch;
      ch          = alphabet[idx];
      c.char_code = ch[CHAR_W-1:0];
      c.last_char = 1'b0;
      c.overflow  = 1'b0;
      return c;
    endfunction

    // One accepted beat: fold it in, and on the final beat queue the whole encoding.
    function void note_beat(in_item_t beat);
      int unsigned total;
      int unsigned emitted;
      if (n_bytes < MAX_BYTES) begin
        n_bytes++;
        if (beat.data_byte == '0 && !nonzero_seen) begin
          n_zeros++;
        end else begin
          nonzero_seen = 1'b1;
          fold(beat.data_byte);
        end
      end else begin
        dropped = 1'b1;
      end
      if (!beat.last_byte) begin
        return;
      end
      total = n_zeros + n_digits;
      if (total > CHAR_CAP) begin
        total   = CHAR_CAP;
        dropped = 1'b1;
      end
      emitted = 0;
      for (int i = 0; i < n_zeros && emitted < total; i++) begin
        chars_due.push_back(char_of(0));
        emitted++;
      end
      for (int i = n_digits; i > 0 && emitted < total; i--) begin
        chars_due.push_back(char_of(digits[i-1] % RADIX));
        emitted++;
      end
      if (emitted > 0) begin
        chars_due[chars_due.size()-1].last_char = 1'b1;
        chars_due[chars_due.size()-1].overflow  = dropped;
      end
      clear();
    endfunction

    function void check_char(out_item_t got);
      out_item_t want;
      if (chars_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("unexpected character: code %0d last %0b overflow %0b",
                   got.char_code, got.last_char, got.overflow);
        end
        return;
      end
      want = chars_due.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch: expected code %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
                   want.char_code, want.last_char, want.overflow,
                   got.char_code, got.last_char, got.overflow);
        end
      end
    endfunction

    function int unsigned pending();
      return chars_due.size();
    endfunction
  endclass

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  in_item_t  data_i = '0;
  logic      busy;
  logic      result_valid_o;
  out_item_t result_o;

  encoding_board sb = new();

  // Message under construction, the count of beats that the block folds in (bytes past
  // MAX_BYTES are ignored and do not count), and whether the sender may idle at present.
  logic [BYTE_W-1:0] msg [$];
  int unsigned       beats_used = 0;
  bit                idle_on    = 1'b1;
  int unsigned       quiet      = 0;
  bit                moved;

  base58_encoder_top #(
    .MAX_BYTES (MAX_BYTES),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .data_i        (data_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Everything is sampled at the rising edge, where the inputs have been steady since the
  // falling edge and the outputs still hold the values of the cycle that is ending. A beat
  // is taken whenever start is high and busy is low; a character whenever the strobe is
  // high. The watchdog counts cycles in which neither happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (start && !busy) begin
        sb.note_beat(data_i);
        moved = 1'b1;
      end
      if (result_valid_o) begin
        sb.check_char(result_o);
        moved = 1'b1;
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Present one beat from the falling edge and hold it until an edge with busy low takes
  // it. While idling is allowed the sender first leaves a random number of empty cycles.
  // start is left high after the beat; the next call either idles or presents new data,
  // so start is never assigned twice in one step.
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
    while (idle_on && $urandom_range(99) < 27) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start            = 1'b1;
    data_i.data_byte = b;
    data_i.last_byte = last;
    do begin
      @(posedge clk_i);
    end while (busy);
    @(negedge clk_i);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg.size(); i++) begin
      send_beat(msg[i], i == msg.size() - 1);
    end
    beats_used += (msg.size() < MAX_BYTES) ? msg.size() : MAX_BYTES;
  endtask

  // Random message shapes. Most are short, since every byte walks each stored digit;
  // some are long, a few fill the byte limit with 0xFF to reach the longest digit string,
  // a few run past the byte limit so that the final character flags the overflow, and a
  // few are all zeros so that the text is nothing but leading ones.
  task automatic build_message(input int unsigned msg_no);
    int unsigned len;
    int unsigned lead;
    int unsigned kind;
    kind = $urandom_range(99);
    if (msg_no == 2) begin
      kind = 90;
    end else if (msg_no == 5) begin
      kind = 95;
    end
    lead = ($urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
    msg.delete();
    if (kind < 70) begin
      len = $urandom_range(1, 8);
    end else if (kind < 88) begin
      len = $urandom_range(9, MAX_BYTES);
    end else if (kind < 93) begin
      len = MAX_BYTES;
      lead = 0;
    end else if (kind < 97) begin
      len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 6);
    end else begin
      len  = $urandom_range(1, MAX_BYTES + 2);
      lead = len;
    end
    for (int i = 0; i < len; i++) begin
      if (i < lead) begin
        msg.push_back(8'h00);
      end else if (kind >= 88 && kind < 93) begin
        msg.push_back(8'hFF);
      end else if ($urandom_range(99) < 10) begin
        msg.push_back(8'h00);
      end else begin
        msg.push_back(BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int unsigned msg_no;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed messages: a lone zero byte, a lone 0xFF, leading zeros before a one, a zero
    // after a nonzero byte, bytes with alternating bit patterns, a zero ahead of 0xFF, and
    // the values that land on the last alphabet character and on the first carry.
    msg = '{8'h00};
    send_message();
    msg = '{8'hFF};
    send_message();
    msg = '{8'h00, 8'h00, 8'h01};
    send_message();
    msg = '{8'h01, 8'h00};
    send_message();
    msg = '{8'h80, 8'h7F, 8'h55, 8'hAA};
    send_message();
    msg = '{8'h00, 8'hFF};
    send_message();
    msg = '{8'h39};
    send_message();
    msg = '{8'h3A};
    send_message();

    // Random messages, with a run of messages early on in which the sender never idles
    // (it takes in the long overflowing message), and one point before it at which the
    // sender holds off until every predicted character has come back.
    msg_no = 0;
    while (beats_used < TARGET_BEATS) begin
      idle_on = !(msg_no >= 4 && msg_no < 10);
      if (msg_no == 3) begin
        start = 1'b0;
        @(negedge clk_i);
        while (sb.pending() != 0) begin
          @(negedge clk_i);
        end
      end
      build_message(msg_no);
      send_message();
      msg_no++;
    end

    start = 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
